/* rtl/lfu_pkg.sv */
package lfu_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int CFG_W        = 5;
   localparam int KEY_W        = 32;
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 16;

   localparam logic [CFG_W-1:0]   CAP_RESET = CFG_W'(16);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_NEW = COUNT_W'(1);
   localparam logic [DATA_W-1:0]  MISS_DATA = '1;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // one slot of the main store; rank lives in its own RAM
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  data;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic age;
      logic commit;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;
      logic cap_zero;
      logic is_put;
      logic found;
   } dp_status_type;

endpackage

/* rtl/lfu_ram.sv */
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lfu_ctrl.sv */
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_SCAN_END = 3'd2;
   localparam logic [2:0] S_DECIDE   = 3'd3;
   localparam logic [2:0] S_AGE      = 3'd4;
   localparam logic [2:0] S_AGE_END  = 3'd5;
   localparam logic [2:0] S_COMMIT   = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = status.cap_zero ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: state_in = S_DECIDE;
         S_DECIDE: begin
            if (status.cap_zero) begin
               state_in = status.is_put ? S_IDLE : S_RESP;
            end else if (!status.is_put && !status.found) begin
               state_in = S_RESP;
            end else begin
               state_in = S_AGE;
            end
         end
         S_AGE: begin
            cmd.age = 1'b1;
            if (status.last) begin
               state_in = S_AGE_END;
            end
         end
         S_AGE_END: state_in = S_COMMIT;
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.is_put ? S_IDLE : S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.respond  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !cmd.respond)
      else $error("response overwritten");

   // a slot write only happens after the aging pass drained
   a_commit_after_age: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(state_ff) == S_AGE_END)
      else $error("commit without aging pass");

   // nothing is accepted while a scan is under way
   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.scan || cmd.age |-> !req_tready)
      else $error("accept during scan");
`endif

endmodule

/* rtl/lfu_dpath.sv */
module lfu_dpath
   import lfu_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [KEY_W+DATA_W-1:0]  req_tdata,
   input  logic                     req_tuser,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   output logic                     rsp_hit,
   output logic [DATA_W-1:0]        rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

   // configuration and occupancy
   logic [CFG_W-1:0]    cap_ff;
   logic [CAPACITY-1:0] valid_ff;
   logic [OCC_W-1:0]    occ_ff;

   // latched request
   logic                op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [DATA_W-1:0]   wval_ff;

   // scan pointer and read pipeline
   logic [IDX_W-1:0]    ptr_ff;
   logic                rd_vld_ff, rd_age_ff;
   logic [IDX_W-1:0]    rd_idx_ff;

   // scan results
   logic                found_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [IDX_W-1:0]    match_rank_ff;
   logic [COUNT_W-1:0]  match_cnt_ff;
   logic [DATA_W-1:0]   match_data_ff;
   logic                vic_vld_ff;
   logic [IDX_W-1:0]    vic_idx_ff;
   logic [IDX_W-1:0]    vic_rank_ff;
   logic [COUNT_W-1:0]  vic_cnt_ff;
   logic                free_vld_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   logic                rsp_hit_ff;
   logic [DATA_W-1:0]   rsp_data_ff;

   // RAM ports
   entry_type           ent_rd, ent_wr;
   logic [IDX_W-1:0]    rank_rd, rank_wr;
   logic                rank_we;
   logic [IDX_W-1:0]    rank_waddr;

   // plan for this request
   logic [CMP_W-1:0]    eff_cap;
   logic                room;
   logic [IDX_W-1:0]    slot;
   logic [IDX_W-1:0]    thr;
   logic                age_all;
   logic                cur_valid;
   logic                last;
   logic                age_hit;

   always_comb begin
      eff_cap = (CMP_W'(cap_ff) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_ff);
      room    = CMP_W'(occ_ff) < eff_cap;
      age_all = !found_ff && room;
      thr     = found_ff ? match_rank_ff : vic_rank_ff;
      if (found_ff) begin
         slot = match_idx_ff;
      end else if (room) begin
         slot = free_idx_ff;
      end else begin
         slot = vic_idx_ff;
      end
      cur_valid = valid_ff[rd_idx_ff];
      last      = (ptr_ff == IDX_W'(CAPACITY - 1));
      age_hit   = rd_vld_ff && rd_age_ff && cur_valid && (age_all || rank_rd < thr);
   end

   always_comb begin
      ent_wr.key  = key_ff;
      ent_wr.data = (found_ff && op_ff == ACT_GET) ? match_data_ff : wval_ff;
      if (!found_ff) begin
         ent_wr.count = COUNT_NEW;
      end else if (match_cnt_ff == COUNT_MAX) begin
         ent_wr.count = match_cnt_ff;
      end else begin
         ent_wr.count = match_cnt_ff + 1'b1;
      end
      rank_we    = cmd.commit || age_hit;
      rank_waddr = cmd.commit ? slot : rd_idx_ff;
      rank_wr    = cmd.commit ? '0 : rank_rd + 1'b1;
   end

   lfu_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot),
      .wr_data (ent_wr),
      .rd_addr (ptr_ff),
      .rd_data (ent_rd)
   );

   lfu_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wr),
      .rd_addr (ptr_ff),
      .rd_data (rank_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         valid_ff  <= '0;
         occ_ff    <= '0;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            ptr_ff <= '0;
         end else if (cmd.scan || cmd.age) begin
            ptr_ff <= last ? '0 : ptr_ff + 1'b1;
         end
         rd_vld_ff <= cmd.scan || cmd.age;
         if (cmd.commit) begin
            valid_ff[slot] <= 1'b1;
            if (age_all) begin
               occ_ff <= occ_ff + 1'b1;
            end
         end
      end
   end

   // payload and scan trackers
   always_ff @(posedge clock) begin
      rd_age_ff <= cmd.age;
      rd_idx_ff <= ptr_ff;
      if (cmd.start) begin
         op_ff       <= req_tuser;
         key_ff      <= req_tdata[KEY_W-1:0];
         wval_ff     <= req_tdata[KEY_W+DATA_W-1:KEY_W];
         found_ff    <= 1'b0;
         vic_vld_ff  <= 1'b0;
         free_vld_ff <= 1'b0;
      end else if (rd_vld_ff && !rd_age_ff) begin
         if (cur_valid) begin
            if (!found_ff && ent_rd.key == key_ff) begin
               found_ff      <= 1'b1;
               match_idx_ff  <= rd_idx_ff;
               match_rank_ff <= rank_rd;
               match_cnt_ff  <= ent_rd.count;
               match_data_ff <= ent_rd.data;
            end
            // lowest count, oldest among equal counts
            if (!vic_vld_ff || ent_rd.count < vic_cnt_ff ||
                (ent_rd.count == vic_cnt_ff && rank_rd > vic_rank_ff)) begin
               vic_vld_ff  <= 1'b1;
               vic_idx_ff  <= rd_idx_ff;
               vic_cnt_ff  <= ent_rd.count;
               vic_rank_ff <= rank_rd;
            end
         end else if (!free_vld_ff) begin
            free_vld_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.respond) begin
         rsp_hit_ff  <= found_ff;
         rsp_data_ff <= found_ff ? match_data_ff : MISS_DATA;
      end
   end

   always_comb begin
      status.last     = last;
      status.cap_zero = (cap_ff == '0);
      status.is_put   = (op_ff == ACT_PUT);
      status.found    = found_ff;
   end

   assign rsp_hit  = rsp_hit_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      OCC_W'($countones(valid_ff)) == occ_ff)
      else $error("occupancy out of step with valid map");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && age_all |-> free_vld_ff)
      else $error("insert with room but no free slot seen");

   a_victim: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !found_ff && !room |-> vic_vld_ff)
      else $error("eviction without a victim");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rd_vld_ff)
      else $error("commit collides with aging write");
`endif

endmodule

/* rtl/lfu_cache_lru_tiebreak_top.sv */
// Channel  Ports                     Payload (low bit first)
// req      req_tvalid/req_tready     tdata: key[31:0], write_value[63:32]; tuser: action
// rsp      rsp_tvalid/rsp_tready     tdata: read_value[31:0]; tuser: hit
// csr      csr_wr_en/csr_wr_data     capacity_in_use[4:0]
//
// One request at a time. Every request scans all CAPACITY slots, one slot per
// cycle through the entry and rank RAM read ports, to find the key, a free
// slot and the eviction victim. A get miss then answers; a hit or put runs
// a second pass over the rank RAM to age newer entries and writes the slot.
// Capacity zero skips both passes. Reset (synchronous) clears the valid map;
// key, data, count and rank RAMs are left as they are. A new request is
// taken while an earlier response still waits on rsp_tready; a get that
// finishes then holds until the response register frees up.
module lfu_cache_lru_tiebreak_top
   import lfu_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [KEY_W+DATA_W-1:0] req_tdata,   // key, write_value
   input  logic [0:0]              req_tuser,   // action
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [DATA_W-1:0]       rsp_tdata,   // read_value
   output logic [0:0]              rsp_tuser,   // hit
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data  // capacity_in_use
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          rsp_hit;

   // sequencer: scan, decide, age, commit, respond
   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // slot storage, comparators and response register
   lfu_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser[0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_hit     (rsp_hit),
      .rsp_data    (rsp_tdata)
   );

   assign rsp_tuser = rsp_hit;

endmodule
